[design/dthist_pkg.sv]
// dthist_pkg: shared constants, types and command/status structs for the
// dwell-time histogram unit. No dependencies.

package dthist_pkg;

    // bin index width and count
    localparam int LEVEL_BITS = 8;
    localparam int BIN_COUNT  = 1 << LEVEL_BITS;

    // field widths
    localparam int LEVEL_W = 8;
    localparam int STAMP_W = 48;
    localparam int SECS_W  = 39;

    // conversion of ms to whole seconds: q = (ms * RECIP) >> RECIP_SHIFT
    localparam int MS_PER_S    = 1000;
    localparam int RECIP_SHIFT = 58;
    localparam int RECIP_W     = 49;
    localparam int PART_W      = 24;
    localparam int PROD_W      = STAMP_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(MS_PER_S - 1)) / 64'(MS_PER_S));

    // largest value a read can report
    localparam logic [SECS_W-1:0] SECS_MAX = SECS_W'(((64'd1 << STAMP_W) - 64'd1) / MS_PER_S);

    typedef logic [LEVEL_BITS-1:0] bin_t;
    typedef logic [STAMP_W-1:0]    stamp_t;
    typedef logic [SECS_W-1:0]     secs_t;

    // operation codes carried in the low bits of tuser
    typedef enum logic [1:0] {
        OP_SAMPLE     = 2'd0,
        OP_READ       = 2'd1,
        OP_READ_CLEAR = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_UPDATE,
        ST_DIV_LOAD,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic fetch;
        logic update;
        logic div_start;
        logic emit;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        op_t  op;
        logic div_done;
        logic out_full;
    } dp_status_t;

endpackage

[design/dthist_div.sv]
// dthist_div: 48-bit millisecond total to whole seconds by multiplying with
// the reciprocal of 1000, one partial product per cycle. Depends on dthist_pkg.

module dthist_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  dthist_pkg::stamp_t      dividend,
    output logic                    done,
    output dthist_pkg::secs_t       quotient
);
    import dthist_pkg::*;

    stamp_t                    dvd_reg, dvd_next;
    logic [PROD_W-1:0]         acc_reg, acc_next;
    logic [1:0]                step_reg, step_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [PART_W-1:0]         dvd_part;
    logic [RECIP_W-PART_W-1:0] recip_part;
    logic [RECIP_W-1:0]        partial;
    logic [PROD_W-1:0]         partial_ext;

    // one partial product per step: dividend half times reciprocal half
    always_comb
    begin
        dvd_part    = step_reg[1] ? dvd_reg[STAMP_W-1:PART_W] : dvd_reg[PART_W-1:0];
        recip_part  = step_reg[0] ? RECIP[RECIP_W-1:PART_W]
                                  : (RECIP_W-PART_W)'(RECIP[PART_W-1:0]);
        partial     = RECIP_W'(dvd_part) * RECIP_W'(recip_part);
        partial_ext = PROD_W'(partial);
        if (step_reg[0])
        begin
            partial_ext = partial_ext << PART_W;
        end
        if (step_reg[1])
        begin
            partial_ext = partial_ext << PART_W;
        end
        dvd_next  = dvd_reg;
        acc_next  = acc_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = dividend;
            acc_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next  = acc_reg + partial_ext;
            step_next = step_reg + 2'd1;
            if (step_reg == 2'd3)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        acc_reg <= acc_next;
    end

    assign done     = done_reg;
    assign quotient = acc_reg[RECIP_SHIFT +: SECS_W];

endmodule

[design/dthist_ctrl.sv]
// dthist_ctrl: sequencing state machine of the histogram unit.
// Depends on dthist_pkg.

module dthist_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  dthist_pkg::dp_status_t status,
    output dthist_pkg::ctrl_cmd_t  cmd
);
    import dthist_pkg::*;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                case (status.op) inside
                    OP_SAMPLE:                state_next = ST_UPDATE;
                    OP_READ, OP_READ_CLEAR:   state_next = ST_DIV_LOAD;
                    default:                  state_next = ST_IDLE;
                endcase
            end
            ST_UPDATE:   state_next = ST_IDLE;
            ST_DIV_LOAD: state_next = ST_DIVIDE;
            ST_DIVIDE:
            begin
                if (status.div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!status.out_full)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_FETCH:    cmd.fetch     = 1'b1;
            ST_UPDATE:   cmd.update    = 1'b1;
            ST_DIV_LOAD: cmd.div_start = 1'b1;
            ST_DIVIDE:   cmd           = '0;
            ST_EMIT:     cmd.emit      = !status.out_full;
            default:     cmd           = '0;
        endcase
    end

endmodule

[design/dthist_dp.sv]
// dthist_dp: item registers, bin memory with occupancy flags, dwell
// arithmetic and output register. Depends on dthist_pkg and dthist_div.

module dthist_dp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  dthist_pkg::ctrl_cmd_t  cmd,
    output dthist_pkg::dp_status_t status,
    input  logic [1:0]             in_op,
    input  logic [7:0]             in_level,
    input  dthist_pkg::stamp_t     in_stamp,
    input  logic                   in_first,
    input  logic                   in_last,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [47:0]            m_tdata,
    output logic                   m_tuser
);
    import dthist_pkg::*;

    // latched item
    logic [1:0] op_reg;
    bin_t       bin_reg;
    stamp_t     stamp_reg;
    logic       first_reg;
    logic       last_reg;

    // held level and time of last change
    bin_t       held_level_reg;
    stamp_t     held_since_reg;

    // bin store and occupancy flags; an unoccupied bin reads as zero
    stamp_t               bins_mem [BIN_COUNT];
    logic [BIN_COUNT-1:0] used_reg;
    stamp_t               rd_data_reg;
    logic                 rd_used_reg;
    stamp_t               elapsed_reg;

    // output register
    logic        m_valid_reg;
    logic [47:0] m_data_reg;
    logic        m_user_reg;

    bin_t        rd_addr;
    logic [STAMP_W:0] diff;
    stamp_t      base;
    logic [STAMP_W:0] sum;
    stamp_t      sum_sat;
    logic        changed;
    logic        do_add;
    logic        div_done;
    secs_t       seconds;

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= in_op;
            bin_reg   <= bin_t'(in_level);
            stamp_reg <= in_stamp;
            first_reg <= in_first;
            last_reg  <= in_last;
        end
    end

    // fetch address and elapsed time
    assign rd_addr = (op_t'(op_reg) == OP_SAMPLE) ? held_level_reg : bin_reg;
    assign diff    = {1'b0, stamp_reg} - {1'b0, held_since_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.fetch)
        begin
            rd_data_reg <= bins_mem[rd_addr];
            rd_used_reg <= used_reg[rd_addr];
            elapsed_reg <= diff[STAMP_W] ? '0 : diff[STAMP_W-1:0];
        end
    end

    // saturating add into the held level's bin
    assign base    = rd_used_reg ? rd_data_reg : '0;
    assign sum     = {1'b0, base} + {1'b0, elapsed_reg};
    assign sum_sat = sum[STAMP_W] ? '1 : sum[STAMP_W-1:0];
    assign changed = (bin_reg != held_level_reg);
    assign do_add  = !first_reg && (changed || (last_reg && (elapsed_reg != '0)));

    always_ff @(posedge clk)
    begin
        if (cmd.update && do_add)
        begin
            bins_mem[held_level_reg] <= sum_sat;
        end
    end

    // occupancy flags, held state; clearing a flag empties its bin
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= '0;
            held_level_reg <= '0;
            held_since_reg <= '0;
        end
        else
        begin
            if (cmd.update)
            begin
                if (do_add)
                begin
                    used_reg[held_level_reg] <= 1'b1;
                end
                if (first_reg || changed)
                begin
                    held_level_reg <= bin_reg;
                    held_since_reg <= stamp_reg;
                end
            end
            if (cmd.emit && (op_t'(op_reg) == OP_READ_CLEAR))
            begin
                used_reg[bin_reg] <= 1'b0;
            end
        end
    end

    // ms to seconds
    dthist_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (base),
        .done     (div_done),
        .quotient (seconds)
    );

    // result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            m_data_reg <= {1'b0, seconds, LEVEL_W'(bin_reg)};
            m_user_reg <= rd_used_reg;
        end
    end

    assign m_tvalid        = m_valid_reg;
    assign m_tdata         = m_data_reg;
    assign m_tuser         = m_user_reg;
    assign status.op       = op_t'(op_reg);
    assign status.div_done = div_done;
    assign status.out_full = m_valid_reg && !m_tready;

endmodule

[design/dwell_time_histogram_unit.sv]
// dwell_time_histogram_unit: top level of the time-at-level histogram.
// Depends on dthist_pkg, dthist_ctrl and dthist_dp.
//
//  channel | direction | tdata                          | tuser              | tlast
//  s_*     | in        | level[7:0] stamp_ms[55:8]      | op[1:0] start[2]   | list_end
//  m_*     | out       | bin_level[7:0] seconds[46:8]   | bin_occupied[0]    | -
//
// a sample passes through accept, bin fetch and read-modify-write of the bin
// a read passes through accept, bin fetch, divider load, the four-step
// multiply by the reciprocal of 1000 and emit before the next accept
// the input is taken again while a result still waits in the output register
// reset clears the occupancy flags at once; no clearing pass is needed
// a stalled result holds only the emit step; m_tready low never loses a beat

module dwell_time_histogram_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // level[7:0], stamp_ms[55:8]
    input  logic [2:0]  s_tuser,   // op[1:0], list_start[2]
    input  logic        s_tlast,   // list_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // bin_level[7:0], bin_seconds[46:8], zero[47]
    output logic [0:0]  m_tuser    // bin_occupied[0]
);
    import dthist_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencer
    dthist_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    dthist_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .in_op    (s_tuser[1:0]),
        .in_level (s_tdata[7:0]),
        .in_stamp (s_tdata[55:8]),
        .in_first (s_tuser[2]),
        .in_last  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser[0])
    );

endmodule

[design/dthist_checker.sv]
// dthist_checker: port-level checks on the histogram unit, bound to the top.
// Depends on dthist_pkg.

module dthist_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [55:0] s_tdata,
    input logic [2:0]  s_tuser,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [0:0]  m_tuser
);
    import dthist_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // one item at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // a result never appears right after an accepted beat
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
        else $error("result too early");

    // reported seconds stay within the saturated total
    a_secs_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[46:8] <= SECS_MAX) && !m_tdata[47])
        else $error("seconds out of range");

    // an empty bin reports zero time
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> (m_tdata[46:8] == '0))
        else $error("empty bin with time");

endmodule

bind dwell_time_histogram_unit dthist_checker u_checker (.*);
